### rtl/lfc_pkg.sv
// shared types, register map and reset values of the line follower controller
package lfc_pkg;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 32;

  // register index, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_BASE_SPEED     = 3'd0,
    REG_SLOW_SPEED     = 3'd1,
    REG_LOST_LIMIT     = 3'd2,
    REG_STOP_DISTANCE  = 3'd3,
    REG_MANEUVER_TICKS = 3'd4,
    REG_PAUSE_TICKS    = 3'd5
  } lfc_reg_idx_t;

  localparam logic [7:0] RST_BASE_SPEED     = 8'd110;
  localparam logic [7:0] RST_SLOW_SPEED     = 8'd80;
  localparam logic [9:0] RST_LOST_LIMIT     = 10'd50;
  localparam logic [8:0] RST_STOP_DISTANCE  = 9'd20;
  localparam logic [9:0] RST_MANEUVER_TICKS = 10'd50;
  localparam logic [9:0] RST_PAUSE_TICKS    = 10'd300;

  typedef enum logic [1:0] {
    DIR_FWD  = 2'd0,
    DIR_REV  = 2'd1,
    DIR_STOP = 2'd2
  } lfc_dir_t;

  typedef enum logic [1:0] {
    BEEP_NONE     = 2'd0,
    BEEP_LOST     = 2'd1,
    BEEP_OBSTACLE = 2'd2
  } lfc_beep_t;

  typedef struct packed {
    logic [7:0] base_speed;
    logic [7:0] slow_speed;
    logic [9:0] lost_limit;
    logic [8:0] stop_distance;
    logic [9:0] maneuver_ticks;
    logic [9:0] pause_ticks;
  } lfc_cfg_t;

  typedef struct packed {
    lfc_dir_t   dir;
    logic [7:0] speed;
  } lfc_motor_t;

  typedef struct packed {
    lfc_motor_t left;
    lfc_motor_t right;
    logic [3:0] mode;
    lfc_beep_t  beep;
  } lfc_result_t;

endpackage

### rtl/lfc_cfg_regs.sv
// apb register file holding the speed, limit and timing settings
module lfc_cfg_regs
  import lfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output lfc_cfg_t              cfg
);

  lfc_cfg_t     cfg_r;
  logic         wr_en;
  lfc_reg_idx_t idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = lfc_reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_speed     <= RST_BASE_SPEED;
      cfg_r.slow_speed     <= RST_SLOW_SPEED;
      cfg_r.lost_limit     <= RST_LOST_LIMIT;
      cfg_r.stop_distance  <= RST_STOP_DISTANCE;
      cfg_r.maneuver_ticks <= RST_MANEUVER_TICKS;
      cfg_r.pause_ticks    <= RST_PAUSE_TICKS;
    end else if (wr_en) begin
      unique case (idx)
        REG_BASE_SPEED:     cfg_r.base_speed     <= cfg_pwdata[7:0];
        REG_SLOW_SPEED:     cfg_r.slow_speed     <= cfg_pwdata[7:0];
        REG_LOST_LIMIT:     cfg_r.lost_limit     <= cfg_pwdata[9:0];
        REG_STOP_DISTANCE:  cfg_r.stop_distance  <= cfg_pwdata[8:0];
        REG_MANEUVER_TICKS: cfg_r.maneuver_ticks <= cfg_pwdata[9:0];
        REG_PAUSE_TICKS:    cfg_r.pause_ticks    <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BASE_SPEED:     cfg_prdata = {24'd0, cfg_r.base_speed};
      REG_SLOW_SPEED:     cfg_prdata = {24'd0, cfg_r.slow_speed};
      REG_LOST_LIMIT:     cfg_prdata = {22'd0, cfg_r.lost_limit};
      REG_STOP_DISTANCE:  cfg_prdata = {23'd0, cfg_r.stop_distance};
      REG_MANEUVER_TICKS: cfg_prdata = {22'd0, cfg_r.maneuver_ticks};
      REG_PAUSE_TICKS:    cfg_prdata = {22'd0, cfg_r.pause_ticks};
      default:            cfg_prdata = '0;
    endcase
  end

endmodule

### rtl/lfc_core.sv
// mode machine, motor command state and result register, one tick per accepted beat
module lfc_core
  import lfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        tick,
  input  logic [2:0]  left_code,
  input  logic [2:0]  right_code,
  input  logic [8:0]  obstacle_dist,
  input  logic        coin,
  input  lfc_cfg_t    cfg,
  output lfc_result_t res
);

  typedef enum logic [3:0] {
    MODE_FOLLOW      = 4'd0,
    MODE_LOST        = 4'd1,
    MODE_PAUSE       = 4'd2,
    MODE_REVERSE     = 4'd3,
    MODE_SEARCH      = 4'd4,
    MODE_REALIGN     = 4'd5,
    MODE_MAN_START   = 4'd6,
    MODE_MAN_WAIT    = 4'd7,
    MODE_MAN_TURN    = 4'd8,
    MODE_WAIT_ALIGN  = 4'd9,
    MODE_SLOW_FWD    = 4'd10,
    MODE_RANDOM_TURN = 4'd11
  } mode_t;

  localparam logic [7:0]  FORCE_LOW     = 8'd20;
  localparam logic [7:0]  FORCE_MID     = 8'd40;
  localparam logic [7:0]  FORCE_HIGH    = 8'd80;
  localparam logic [7:0]  SPIRAL_PERIOD = 8'd240;
  localparam logic [7:0]  SPIRAL_FIRST  = 8'd70;
  localparam logic [7:0]  SPIRAL_STEP   = 8'd20;
  localparam logic [2:0]  SEEN_MAX      = 3'd7;
  localparam logic [2:0]  SEEN_FOUND    = 3'd5;
  localparam logic [10:0] LOST_CNT_MAX  = 11'h7FF;

  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  function automatic logic [7:0] sat_sub(input logic [7:0] a, input logic [7:0] b);
    return (a < b) ? 8'd0 : a - b;
  endfunction

  function automatic logic [7:0] force_of(input logic [2:0] c);
    return c[2] ? FORCE_HIGH : (c[1] ? FORCE_MID : FORCE_LOW);
  endfunction

  function automatic lfc_motor_t fwd(input logic [7:0] s);
    lfc_motor_t m;
    m.dir   = DIR_FWD;
    m.speed = s;
    return m;
  endfunction

  mode_t       mode_r, mode_nxt;
  lfc_motor_t  lmot_r, lmot_nxt, rmot_r, rmot_nxt;
  logic [10:0] lost_cnt_r, lost_cnt_nxt;
  logic        line_lost_r, line_lost_nxt;
  logic        running_r, running_nxt;
  logic [10:0] rev_cnt_r, rev_cnt_nxt;
  logic [7:0]  spiral_ticks_r, spiral_ticks_nxt;
  logic [7:0]  spiral_spd_r, spiral_spd_nxt;
  logic [2:0]  seen_r, seen_nxt;
  logic        turn_left_r, turn_left_nxt;
  logic [9:0]  wait_r, wait_nxt;
  lfc_result_t res_r, res_nxt;
  lfc_beep_t   beep;

  lfc_motor_t  stop_m;
  logic [2:0]  l, r;
  logic [7:0]  base;

  assign stop_m = '{dir: DIR_STOP, speed: 8'd0};
  assign l      = left_code;
  assign r      = right_code;
  assign base   = cfg.base_speed;
  assign res    = res_r;

  always_comb begin
    mode_nxt         = mode_r;
    lmot_nxt         = lmot_r;
    rmot_nxt         = rmot_r;
    lost_cnt_nxt     = lost_cnt_r;
    line_lost_nxt    = line_lost_r;
    running_nxt      = running_r;
    rev_cnt_nxt      = rev_cnt_r;
    spiral_ticks_nxt = spiral_ticks_r;
    spiral_spd_nxt   = spiral_spd_r;
    seen_nxt         = seen_r;
    turn_left_nxt    = turn_left_r;
    wait_nxt         = (wait_r != 10'd0) ? wait_r - 10'd1 : 10'd0;
    beep             = BEEP_NONE;

    unique case (mode_r)
      MODE_FOLLOW: begin
        if (obstacle_dist != 9'd0 && obstacle_dist < cfg.stop_distance) begin
          if (running_r) begin
            lmot_nxt    = stop_m;
            rmot_nxt    = stop_m;
            beep        = BEEP_OBSTACLE;
            running_nxt = 1'b0;
          end
        end else begin
          running_nxt = 1'b1;
          if (l == 3'd7 && r == 3'd7) begin
            // no ground under the sensors
            lmot_nxt = stop_m;
            rmot_nxt = stop_m;
          end else if (l == 3'd0 && r == 3'd0) begin
            lmot_nxt = fwd(base);
            rmot_nxt = fwd(base);
            if (lost_cnt_r > {1'b0, cfg.lost_limit}) line_lost_nxt = 1'b1;
            if (lost_cnt_r != LOST_CNT_MAX) lost_cnt_nxt = lost_cnt_r + 11'd1;
          end else begin
            lost_cnt_nxt = 11'd0;
            if (r != 3'd0) begin
              rmot_nxt = fwd(sat_sub(base, force_of(r)));
              lmot_nxt = fwd(sat_add(base, force_of(r)));
            end
            // left turn wins over right
            if (l != 3'd0) begin
              rmot_nxt = fwd(sat_add(base, force_of(l)));
              lmot_nxt = fwd(sat_sub(base, force_of(l)));
            end
          end
        end
        if (line_lost_nxt) begin
          beep     = BEEP_LOST;
          mode_nxt = MODE_LOST;
        end
      end
      MODE_LOST: begin
        lmot_nxt = stop_m;
        rmot_nxt = stop_m;
        wait_nxt = cfg.pause_ticks;
        mode_nxt = MODE_PAUSE;
      end
      MODE_PAUSE: begin
        if (wait_nxt == 10'd0) begin
          rev_cnt_nxt = {1'b0, cfg.lost_limit} + {2'b00, cfg.lost_limit[9:1]};
          mode_nxt    = MODE_REVERSE;
        end
      end
      MODE_REVERSE: begin
        if (rev_cnt_r != 11'd0) begin
          lmot_nxt    = '{dir: DIR_REV, speed: base};
          rmot_nxt    = '{dir: DIR_REV, speed: base};
          rev_cnt_nxt = rev_cnt_r - 11'd1;
        end else begin
          spiral_ticks_nxt = 8'd0;
          spiral_spd_nxt   = 8'd0;
          mode_nxt         = MODE_SEARCH;
        end
      end
      MODE_SEARCH: begin
        rmot_nxt         = fwd(base);
        lmot_nxt         = fwd(spiral_spd_r);
        spiral_ticks_nxt = spiral_ticks_r + 8'd1;
        if (spiral_ticks_nxt >= SPIRAL_PERIOD) begin
          spiral_ticks_nxt = 8'd0;
          spiral_spd_nxt   = (spiral_spd_r == 8'd0) ? SPIRAL_FIRST
                                                    : sat_add(spiral_spd_r, SPIRAL_STEP);
        end
        if (l != 3'd0 || r != 3'd0) begin
          seen_nxt = (seen_r == SEEN_MAX) ? SEEN_MAX : seen_r + 3'd1;
        end else begin
          seen_nxt = 3'd0;
        end
        if (seen_nxt >= SEEN_FOUND) begin
          lmot_nxt = stop_m;
          rmot_nxt = stop_m;
          mode_nxt = MODE_REALIGN;
        end
      end
      MODE_REALIGN: begin
        // later matches override earlier ones
        if ((l == 3'd6 && r == 3'd0) || (l == 3'd3 && r == 3'd0) || (l == 3'd7 && r == 3'd0) ||
            (l == 3'd3 && r == 3'd1) || (l == 3'd7 && r == 3'd1) || (l == 3'd3 && r == 3'd3) ||
            (l == 3'd7 && r == 3'd3)) begin
          turn_left_nxt = 1'b0;
          mode_nxt      = MODE_MAN_START;
        end
        if ((r == 3'd6 && l == 3'd0) || (r == 3'd3 && l == 3'd0) || (r == 3'd7 && l == 3'd0) ||
            (r == 3'd3 && l == 3'd1) || (r == 3'd7 && l == 3'd1) ||
            (r == 3'd7 && l == 3'd3)) begin
          turn_left_nxt = 1'b1;
          mode_nxt      = MODE_MAN_START;
        end
        if ((l == 3'd7 && r == 3'd7) || (l == 3'd3 && r == 3'd3) ||
            (l == 3'd1 && r == 3'd1)) begin
          turn_left_nxt = coin;
          mode_nxt      = MODE_MAN_START;
        end
        if (l == 3'd0 && r == 3'd0) mode_nxt = MODE_RANDOM_TURN;
        if ((l == 3'd4 && r == 3'd0) || (l == 3'd2 && r == 3'd0) ||
            (r == 3'd4 && l == 3'd0) || (r == 3'd2 && l == 3'd0)) begin
          mode_nxt = MODE_SLOW_FWD;
        end
        if ((l == 3'd1 && r == 3'd0) || (r == 3'd1 && l == 3'd0)) begin
          line_lost_nxt = 1'b0;
          mode_nxt      = MODE_FOLLOW;
        end
      end
      MODE_MAN_START: begin
        wait_nxt = cfg.maneuver_ticks;
        lmot_nxt = fwd(cfg.slow_speed);
        rmot_nxt = fwd(cfg.slow_speed);
        mode_nxt = MODE_MAN_WAIT;
      end
      MODE_MAN_WAIT: begin
        if (wait_nxt == 10'd0) mode_nxt = MODE_MAN_TURN;
      end
      MODE_MAN_TURN: begin
        if (turn_left_r) begin
          rmot_nxt = fwd(cfg.slow_speed);
          lmot_nxt = stop_m;
        end else begin
          lmot_nxt = fwd(cfg.slow_speed);
          rmot_nxt = stop_m;
        end
        mode_nxt = MODE_WAIT_ALIGN;
      end
      MODE_WAIT_ALIGN: begin
        if (l == 3'd1 || r == 3'd1) begin
          line_lost_nxt = 1'b0;
          mode_nxt      = MODE_FOLLOW;
        end
      end
      MODE_SLOW_FWD: begin
        lmot_nxt = fwd(cfg.slow_speed);
        rmot_nxt = fwd(cfg.slow_speed);
        mode_nxt = MODE_WAIT_ALIGN;
      end
      MODE_RANDOM_TURN: begin
        if (coin) begin
          rmot_nxt = fwd(cfg.slow_speed);
          lmot_nxt = stop_m;
        end else begin
          lmot_nxt = fwd(cfg.slow_speed);
          rmot_nxt = stop_m;
        end
        mode_nxt = MODE_WAIT_ALIGN;
      end
      default: mode_nxt = MODE_FOLLOW;
    endcase

    res_nxt.left  = lmot_nxt;
    res_nxt.right = rmot_nxt;
    res_nxt.mode  = mode_nxt;
    res_nxt.beep  = beep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_FOLLOW;
      lmot_r         <= '{dir: DIR_STOP, speed: 8'd0};
      rmot_r         <= '{dir: DIR_STOP, speed: 8'd0};
      lost_cnt_r     <= 11'd0;
      line_lost_r    <= 1'b0;
      running_r      <= 1'b0;
      rev_cnt_r      <= 11'd0;
      spiral_ticks_r <= 8'd0;
      spiral_spd_r   <= 8'd0;
      seen_r         <= 3'd0;
      turn_left_r    <= 1'b1;
      wait_r         <= 10'd0;
    end else if (tick) begin
      mode_r         <= mode_nxt;
      lmot_r         <= lmot_nxt;
      rmot_r         <= rmot_nxt;
      lost_cnt_r     <= lost_cnt_nxt;
      line_lost_r    <= line_lost_nxt;
      running_r      <= running_nxt;
      rev_cnt_r      <= rev_cnt_nxt;
      spiral_ticks_r <= spiral_ticks_nxt;
      spiral_spd_r   <= spiral_spd_nxt;
      seen_r         <= seen_nxt;
      turn_left_r    <= turn_left_nxt;
      wait_r         <= wait_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      res_r <= res_nxt;
    end
  end

endmodule

### rtl/line_follower_controller.sv
// top level of the line follower controller: stream ports, register port and mode machine
// Each input beat is one control tick: left and right 3-bit line sensor codes, the front
// obstacle distance and a random bit. The tick advances the mode machine (follow, lost,
// pause, reverse, spiral search, realign and the maneuver steps) and yields exactly one
// result beat with both motor commands, the mode reached and a beep code. A tick is worked
// out combinationally between the held state and the result register; one beat is taken
// every cycle unless the output stalls, its result appearing in the next cycle. A new beat
// gets in when the result register is empty or being taken in the same cycle. The user must
// write settings through the register port while no tick is in flight (not enforced).
module line_follower_controller
  import lfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [2:0] left_code, [5:3] right_code, [14:6] obstacle_dist, [15] coin
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] left_dir, [9:2] left_speed, [11:10] right_dir, [19:12] right_speed,
  // [23:20] mode, [25:24] beep, [31:26] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  lfc_cfg_t    cfg;
  lfc_result_t res;
  logic        in_beat;
  logic        out_valid_r, out_valid_nxt;

  assign in_tready     = !out_valid_r || out_tready;
  assign in_beat       = in_tvalid && in_tready;
  assign out_valid_nxt = in_beat || (out_valid_r && !out_tready);
  assign out_tvalid    = out_valid_r;

  assign out_tdata = {6'd0, res.beep, res.mode, res.right.speed, res.right.dir,
                      res.left.speed, res.left.dir};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  lfc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lfc_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick          (in_beat),
    .left_code     (in_tdata[2:0]),
    .right_code    (in_tdata[5:3]),
    .obstacle_dist (in_tdata[14:6]),
    .coin          (in_tdata[15]),
    .cfg           (cfg),
    .res           (res)
  );

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

  a_beat_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> out_tvalid)
    else $error("accepted beat produced no result");

  a_left_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] == DIR_STOP) |-> out_tdata[9:2] == 8'd0)
    else $error("stopped left motor with nonzero speed");

  a_right_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[11:10] == DIR_STOP) |-> out_tdata[19:12] == 8'd0)
    else $error("stopped right motor with nonzero speed");

  a_obstacle_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[25:24] == BEEP_OBSTACLE) |->
      (out_tdata[1:0] == DIR_STOP && out_tdata[11:10] == DIR_STOP))
    else $error("obstacle beep without both motors stopped");

endmodule

### test/tb_top.sv
// self-checking testbench of the line follower controller: tick stimulus, command prediction
module tb_top;
  import lfc_pkg::*;

  localparam int QUIET_LIMIT    = 3000;
  localparam int PRESSURE_PHASE = 1;

  typedef enum logic [3:0] {
    MODE_FOLLOW      = 4'd0,
    MODE_LOST        = 4'd1,
    MODE_PAUSE       = 4'd2,
    MODE_REVERSE     = 4'd3,
    MODE_SEARCH      = 4'd4,
    MODE_REALIGN     = 4'd5,
    MODE_CREEP_START = 4'd6,
    MODE_CREEP_WAIT  = 4'd7,
    MODE_PIVOT       = 4'd8,
    MODE_ALIGN_WAIT  = 4'd9,
    MODE_SLOW_FWD    = 4'd10,
    MODE_RANDOM_TURN = 4'd11
  } tick_mode_t;

  // mirrors the mode machine and holds the motor commands each accepted tick must produce
  class motion_scoreboard;
    lfc_cfg_t    cfg;
    tick_mode_t  mode;
    lfc_motor_t  lmot, rmot;
    logic [10:0] lost_count, reverse_count;
    bit          line_lost, running, turn_left;
    logic [7:0]  spiral_ticks, spiral_speed;
    logic [2:0]  seen_filter;
    logic [9:0]  wait_timer;
    lfc_result_t pending_cmds[$];
    int          errors, checked, ticks, lost_beeps, obstacle_beeps, top_spiral;
    bit [11:0]   modes_seen;

    function new();
      cfg = '{RST_BASE_SPEED, RST_SLOW_SPEED, RST_LOST_LIMIT, RST_STOP_DISTANCE,
              RST_MANEUVER_TICKS, RST_PAUSE_TICKS};
      mode = MODE_FOLLOW;
      lmot = '{DIR_STOP, 8'd0};
      rmot = '{DIR_STOP, 8'd0};
      lost_count = '0; reverse_count = '0;
      line_lost = 0; running = 0; turn_left = 1;
      spiral_ticks = '0; spiral_speed = '0; seen_filter = '0; wait_timer = '0;
      errors = 0; checked = 0; ticks = 0; lost_beeps = 0; obstacle_beeps = 0; top_spiral = 0;
      modes_seen = '0;
    endfunction

    function void set_reg(lfc_reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_BASE_SPEED:     cfg.base_speed     = value[7:0];
        REG_SLOW_SPEED:     cfg.slow_speed     = value[7:0];
        REG_LOST_LIMIT:     cfg.lost_limit     = value[9:0];
        REG_STOP_DISTANCE:  cfg.stop_distance  = value[8:0];
        REG_MANEUVER_TICKS: cfg.maneuver_ticks = value[9:0];
        REG_PAUSE_TICKS:    cfg.pause_ticks    = value[9:0];
        default: ;
      endcase
    endfunction

    function int clip8(int v);
      return (v < 0) ? 0 : ((v > 255) ? 255 : v);
    endfunction

    function void set_motor(bit right_side, lfc_dir_t d, int s);
      lfc_motor_t m;
      m.dir = d;
      m.speed = (d == DIR_STOP) ? 8'd0 : 8'(clip8(s));
      if (right_side) rmot = m;
      else lmot = m;
    endfunction

    function void stop_both();
      set_motor(0, DIR_STOP, 0);
      set_motor(1, DIR_STOP, 0);
    endfunction

    // positive force turns left, negative turns right
    function void steer(int f);
      set_motor(1, DIR_FWD, int'(cfg.base_speed) + f);
      set_motor(0, DIR_FWD, int'(cfg.base_speed) - f);
    endfunction

    function void pivot(bit to_left);
      if (to_left) begin
        set_motor(1, DIR_FWD, int'(cfg.slow_speed));
        set_motor(0, DIR_STOP, 0);
      end else begin
        set_motor(0, DIR_FWD, int'(cfg.slow_speed));
        set_motor(1, DIR_STOP, 0);
      end
    endfunction

    function void creep();
      set_motor(0, DIR_FWD, int'(cfg.slow_speed));
      set_motor(1, DIR_FWD, int'(cfg.slow_speed));
    endfunction

    function int turn_force(logic [2:0] c);
      return (c >= 3'd4) ? 80 : ((c >= 3'd2) ? 40 : 20);
    endfunction

    function lfc_beep_t follow_line(logic [2:0] l, logic [2:0] r, logic [8:0] obst);
      lfc_beep_t beep;
      beep = BEEP_NONE;
      if (obst != 0 && obst < cfg.stop_distance) begin
        if (running) begin
          stop_both();
          beep = BEEP_OBSTACLE;
          running = 0;
        end
        return beep;
      end
      running = 1;
      if (l == 3'd7 && r == 3'd7) begin
        stop_both();
        return BEEP_NONE;
      end
      if (l == 3'd0 && r == 3'd0) begin
        set_motor(0, DIR_FWD, int'(cfg.base_speed));
        set_motor(1, DIR_FWD, int'(cfg.base_speed));
        if (lost_count > cfg.lost_limit) line_lost = 1;
        if (lost_count < 11'd2047) lost_count++;
      end else begin
        lost_count = '0;
        if (r != 0) steer(-turn_force(r));
        if (l != 0) steer(turn_force(l));
      end
      return BEEP_NONE;
    endfunction

    // spiral: slow wheel starts at zero, jumps to 70, then +20 every 240 ticks
    function bit spiral_step(logic [2:0] l, logic [2:0] r);
      set_motor(1, DIR_FWD, int'(cfg.base_speed));
      set_motor(0, DIR_FWD, int'(spiral_speed));
      spiral_ticks = spiral_ticks + 8'd1;
      if (spiral_ticks >= 8'd240) begin
        spiral_ticks = '0;
        if (spiral_speed == 0) spiral_speed = 8'd70;
        else spiral_speed = 8'(clip8(int'(spiral_speed) + 20));
      end
      if (int'(spiral_speed) > top_spiral) top_spiral = int'(spiral_speed);
      if (l != 0 || r != 0) begin
        if (seen_filter < 3'd7) seen_filter++;
      end else begin
        seen_filter = '0;
      end
      return seen_filter >= 3'd5;
    endfunction

    // later matches override earlier ones
    function void realign(logic [2:0] l, logic [2:0] r, logic coin);
      if ((l == 6 && r == 0) || (l == 3 && r == 0) || (l == 7 && r == 0) ||
          (l == 3 && r == 1) || (l == 7 && r == 1) || (l == 3 && r == 3) ||
          (l == 7 && r == 3)) begin
        turn_left = 0;
        mode = MODE_CREEP_START;
      end
      if ((r == 6 && l == 0) || (r == 3 && l == 0) || (r == 7 && l == 0) ||
          (r == 3 && l == 1) || (r == 7 && l == 1) || (r == 7 && l == 3)) begin
        turn_left = 1;
        mode = MODE_CREEP_START;
      end
      if ((l == 7 && r == 7) || (l == 3 && r == 3) || (l == 1 && r == 1)) begin
        turn_left = coin;
        mode = MODE_CREEP_START;
      end
      if (l == 0 && r == 0) mode = MODE_RANDOM_TURN;
      if ((l == 4 && r == 0) || (l == 2 && r == 0) || (r == 4 && l == 0) || (r == 2 && l == 0))
        mode = MODE_SLOW_FWD;
      if ((l == 1 && r == 0) || (r == 1 && l == 0)) begin
        line_lost = 0;
        mode = MODE_FOLLOW;
      end
    endfunction

    function lfc_result_t predict_tick(logic [2:0] l, logic [2:0] r, logic [8:0] obst,
                                       logic coin);
      lfc_result_t res;
      lfc_beep_t   beep;
      beep = BEEP_NONE;
      if (wait_timer != 0) wait_timer--;
      case (mode)
        MODE_FOLLOW: begin
          beep = follow_line(l, r, obst);
          if (line_lost) begin
            beep = BEEP_LOST;
            mode = MODE_LOST;
          end
        end
        MODE_LOST: begin
          stop_both();
          wait_timer = cfg.pause_ticks;
          mode = MODE_PAUSE;
        end
        MODE_PAUSE: begin
          if (wait_timer == 0) begin
            reverse_count = 11'(cfg.lost_limit) + 11'(cfg.lost_limit >> 1);
            mode = MODE_REVERSE;
          end
        end
        MODE_REVERSE: begin
          if (reverse_count != 0) begin
            set_motor(1, DIR_REV, int'(cfg.base_speed));
            set_motor(0, DIR_REV, int'(cfg.base_speed));
            reverse_count--;
          end else begin
            spiral_ticks = '0;
            spiral_speed = '0;
            mode = MODE_SEARCH;
          end
        end
        MODE_SEARCH: begin
          if (spiral_step(l, r)) begin
            stop_both();
            mode = MODE_REALIGN;
          end
        end
        MODE_REALIGN: realign(l, r, coin);
        MODE_CREEP_START: begin
          wait_timer = cfg.maneuver_ticks;
          creep();
          mode = MODE_CREEP_WAIT;
        end
        MODE_CREEP_WAIT: if (wait_timer == 0) mode = MODE_PIVOT;
        MODE_PIVOT: begin
          pivot(turn_left);
          mode = MODE_ALIGN_WAIT;
        end
        MODE_ALIGN_WAIT: begin
          if (l == 1 || r == 1) begin
            line_lost = 0;
            mode = MODE_FOLLOW;
          end
        end
        MODE_SLOW_FWD: begin
          creep();
          mode = MODE_ALIGN_WAIT;
        end
        MODE_RANDOM_TURN: begin
          pivot(coin);
          mode = MODE_ALIGN_WAIT;
        end
        default: mode = MODE_FOLLOW;
      endcase
      if (beep == BEEP_LOST) lost_beeps++;
      if (beep == BEEP_OBSTACLE) obstacle_beeps++;
      res.left  = lmot;
      res.right = rmot;
      res.mode  = mode;
      res.beep  = beep;
      return res;
    endfunction

    function void note_tick(logic [15:0] tick);
      pending_cmds.push_back(predict_tick(tick[2:0], tick[5:3], tick[14:6], tick[15]));
      modes_seen[mode] = 1'b1;
      ticks++;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("mismatch: %s", what);
    endtask

    task cmp_field(string name, int got, int want);
      if (got != want)
        report($sformatf("result %0d %s got %0d want %0d", checked, name, got, want));
    endtask

    task check_result(logic [31:0] word);
      lfc_result_t want;
      if (pending_cmds.size() == 0) begin
        report($sformatf("result beat %h with nothing pending", word));
        return;
      end
      want = pending_cmds.pop_front();
      cmp_field("left_dir",    word[1:0],   want.left.dir);
      cmp_field("left_speed",  word[9:2],   want.left.speed);
      cmp_field("right_dir",   word[11:10], want.right.dir);
      cmp_field("right_speed", word[19:12], want.right.speed);
      cmp_field("mode",        word[23:20], want.mode);
      cmp_field("beep",        word[25:24], want.beep);
      cmp_field("pad",         word[31:26], 0);
      checked++;
    endtask
  endclass

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  // [2:0] left_code, [5:3] right_code, [14:6] obstacle_dist, [15] coin
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  // [1:0] left_dir, [9:2] left_speed, [11:10] right_dir, [19:12] right_speed,
  // [23:20] mode, [25:24] beep, [31:26] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  motion_scoreboard sb;
  int phase_no  = 0;
  int stall_pct = 0;

  line_follower_controller i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls plus one long hold-off in the pressure phase
  initial begin : rx_side
    int  hold_left;
    bit  pressure_done;
    hold_left = 0;
    pressure_done = 0;
    forever begin
      @(posedge clk);
      if (phase_no == PRESSURE_PHASE && !pressure_done) begin
        pressure_done = 1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) quiet = 0;
      else quiet++;
    end
    $display("timeout: no beat for %0d cycles", quiet);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [15:0] pack_tick(logic [2:0] l, logic [2:0] r, logic [8:0] obst,
                                            logic coin);
    return {coin, obst, r, l};
  endfunction

  // steered by the predicted mode so that runs get past follow into the search and maneuvers
  function automatic logic [15:0] make_tick();
    logic [2:0] l, r;
    logic [8:0] obst;
    logic       coin;
    int         pick;
    l = 3'($urandom_range(7));
    r = 3'($urandom_range(7));
    obst = 9'($urandom_range(511));
    coin = 1'($urandom_range(1));
    pick = $urandom_range(99);
    case (sb.mode)
      MODE_FOLLOW: begin
        if (pick < 35) begin
          l = 0;
          r = 0;
          if (pick < 25) obst = 0;
        end else if (pick < 45) begin
          obst = 9'($urandom_range(sb.cfg.stop_distance));
        end else if (pick < 50) begin
          l = 7;
          r = 7;
        end
      end
      MODE_SEARCH: begin
        if (pick < 70) begin
          if (l == 0 && r == 0) l = 3'($urandom_range(1, 7));
        end else begin
          l = 0;
          r = 0;
        end
      end
      MODE_ALIGN_WAIT: begin
        if (pick < 30) begin
          if (coin) l = 1;
          else r = 1;
        end
      end
      default: ;
    endcase
    return pack_tick(l, r, obst, coin);
  endfunction

  task automatic send_tick(logic [15:0] tick);
    in_tvalid <= 1'b1;
    in_tdata  <= tick;
    do @(posedge clk); while (!in_tready);
    sb.note_tick(tick);
  endtask

  task automatic run_ticks(int count, int idle_pct);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < idle_pct) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < idle_pct);
      end
      send_tick(make_tick());
      sent++;
    end
    in_tvalid <= 1'b0;
  endtask

  // setup phase then access phase; psel stays up across back-to-back writes
  task automatic cfg_write(lfc_reg_idx_t idx, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, value);
  endtask

  task automatic write_settings(int base, int slow, int lost, int stop, int man, int pause);
    while (sb.pending_cmds.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_write(REG_BASE_SPEED, base);
    cfg_write(REG_SLOW_SPEED, slow);
    cfg_write(REG_LOST_LIMIT, lost);
    cfg_write(REG_STOP_DISTANCE, stop);
    cfg_write(REG_MANEUVER_TICKS, man);
    cfg_write(REG_PAUSE_TICKS, pause);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic random_settings();
    write_settings($urandom_range(255), $urandom_range(255), $urandom_range(6),
                   $urandom_range(60), $urandom_range(8), $urandom_range(8));
  endtask

  initial begin : main_flow
    logic [15:0] directed[$];
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // follow mode corners under reset settings
    directed = '{
      pack_tick(0, 0, 5, 0),     // obstacle while not yet running: silent
      pack_tick(1, 0, 0, 1),
      pack_tick(0, 0, 10, 0),    // obstacle while running: beep
      pack_tick(0, 1, 20, 0),    // distance equal to the stop limit does not stop
      pack_tick(2, 0, 100, 1),
      pack_tick(3, 0, 0, 0),
      pack_tick(4, 0, 0, 1),
      pack_tick(7, 0, 511, 0),
      pack_tick(0, 2, 0, 0),
      pack_tick(0, 3, 0, 1),
      pack_tick(0, 4, 0, 0),
      pack_tick(0, 7, 0, 1),
      pack_tick(7, 7, 0, 0),     // no ground
      pack_tick(4, 4, 0, 1),     // left turn wins
      pack_tick(5, 6, 511, 1),
      pack_tick(0, 0, 1, 0),     // nearest obstacle
      pack_tick(0, 0, 19, 1),
      pack_tick(0, 0, 0, 1),
      pack_tick(1, 7, 21, 0),
      pack_tick(6, 5, 256, 1)
    };
    foreach (directed[i]) send_tick(directed[i]);
    in_tvalid <= 1'b0;

    write_settings(110, 80, 2, 20, 3, 4);
    phase_no = PRESSURE_PHASE;
    stall_pct = 0;
    run_ticks(300, 0);

    random_settings();
    phase_no = 2;
    run_ticks(220, 85);

    random_settings();
    phase_no = 3;
    stall_pct = 85;
    run_ticks(220, 0);

    random_settings();
    phase_no = 4;
    stall_pct = 34;
    run_ticks(220, 34);

    write_settings(255, 255, 0, 511, 0, 0);
    phase_no = 5;
    stall_pct = 0;
    run_ticks(120, 0);

    write_settings(0, 0, 1023, 0, 1023, 1023);
    phase_no = 6;
    run_ticks(80, 0);

    // short pause and maneuvers so the search and realign steps come around often
    write_settings(110, 80, 0, 20, 1, 1);
    phase_no = 7;
    run_ticks(60, 0);

    while (sb.pending_cmds.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d ticks over %0d setting phases, %0d results checked, %0d mismatches",
             sb.ticks, phase_no + 1, sb.checked, sb.errors);
    $display("modes reached %b, spiral peak %0d, %0d line-lost and %0d obstacle beeps",
             sb.modes_seen, sb.top_spiral, sb.lost_beeps, sb.obstacle_beeps);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### line_follower_controller.f
rtl/lfc_pkg.sv
rtl/lfc_cfg_regs.sv
rtl/lfc_core.sv
rtl/line_follower_controller.sv
test/tb_top.sv
